// File: hw/rtl/vrte_pkg.sv
// Shared constants, types and saturating arithmetic for the giant tour evaluator.
package vrte_pkg;

	// Field and accumulator widths
	localparam int SUM_W  = 24;
	localparam int DEM_W  = 16;
	localparam int CAP_W  = 24;
	localparam int NCNT_W = 8;
	localparam int CMD_W  = 2;
	localparam int IDA_W  = 8;
	localparam int IDB_W  = 7;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// Sizing defaults
	localparam int DEF_MAX_NODES = 128;
	localparam int CMD_Q_DEPTH   = 4;
	localparam int OUT_Q_DEPTH   = 8;

	localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
	localparam logic [CAP_W-1:0]  CAP_RESET  = 24'hFFFFFF;
	localparam logic [NCNT_W-1:0] NCNT_RESET = 8'd128;

	// Input commands
	localparam logic [CMD_W-1:0] CMD_DEMAND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DIST   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TOUR   = 2'd2;

	// Operations carried from front to back
	localparam logic [1:0] OP_DEMAND = 2'd0;
	localparam logic [1:0] OP_DIST   = 2'd1;
	localparam logic [1:0] OP_TOUR   = 2'd2;

	// Register index, taken from address bit 2
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_NODES    = 1'b1;

	typedef struct packed {
		logic [1:0] op;
		logic       last;
	} vrte_ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0] len;
		logic [SUM_W-1:0] exc;
		logic             feas;
	} vrte_res_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] over_cap(input logic [SUM_W-1:0] d,
		input logic [CAP_W-1:0] cap);
		return (d > cap) ? (d - cap) : '0;
	endfunction

endpackage

// File: hw/rtl/vrte_queue.sv
// Small register FIFO used for the command and result queues.
module vrte_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/vrte_front.sv
// Front part: configuration registers, command decode and depot alias mapping.
module vrte_front #(
	parameter int MAX_NODES = vrte_pkg::DEF_MAX_NODES,
	parameter int NW        = $clog2(MAX_NODES)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vrte_pkg::ADDR_W-1:0] paddr,
	input  logic [vrte_pkg::DATA_W-1:0] pwdata,
	output logic [vrte_pkg::DATA_W-1:0] prdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [vrte_pkg::CMD_W-1:0]  cmd,
	input  logic [vrte_pkg::IDA_W-1:0]  node_a,
	input  logic [vrte_pkg::IDB_W-1:0]  node_b,
	input  logic [vrte_pkg::DEM_W-1:0]  value,
	input  logic                        last,
	input  logic                        q_full,
	output logic                        q_push,
	output vrte_pkg::vrte_ctl_t         q_ctl,
	output logic [NW-1:0]               q_node,
	output logic [NW-1:0]               q_col,
	output logic [vrte_pkg::DEM_W-1:0]  q_value,
	output logic [vrte_pkg::CAP_W-1:0]  capacity
);

	logic [vrte_pkg::CAP_W-1:0]  cap_q;
	logic [vrte_pkg::NCNT_W-1:0] ncnt_q;
	logic [31:0]                 a_ext;
	logic [31:0]                 b_ext;
	logic                        a_in;
	logic                        b_in;
	logic                        is_alias;
	logic [NW-1:0]               node_map;
	logic                        keep;
	logic                        cfg_wr;

	assign cfg_wr   = psel && penable && pwrite;
	assign capacity = cap_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= vrte_pkg::CAP_RESET;
			ncnt_q <= vrte_pkg::NCNT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				vrte_pkg::REG_CAPACITY: cap_q  <= pwdata[vrte_pkg::CAP_W-1:0];
				vrte_pkg::REG_NODES:    ncnt_q <= pwdata[vrte_pkg::NCNT_W-1:0];
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		unique case (paddr[2])
			vrte_pkg::REG_CAPACITY:
				prdata = {{(vrte_pkg::DATA_W - vrte_pkg::CAP_W){1'b0}}, cap_q};
			vrte_pkg::REG_NODES:
				prdata = {{(vrte_pkg::DATA_W - vrte_pkg::NCNT_W){1'b0}}, ncnt_q};
		endcase
	end

	// Map aliases and ids beyond the tables to the depot
	assign a_ext    = 32'(node_a);
	assign b_ext    = 32'(node_b);
	assign a_in     = (a_ext < MAX_NODES);
	assign b_in     = (b_ext < MAX_NODES);
	assign is_alias = (node_a >= ncnt_q) || !a_in;
	assign node_map = is_alias ? '0 : a_ext[NW-1:0];

	// Classify the beat; drop unknown commands and out-of-range loads
	always_comb begin
		keep       = 1'b0;
		q_ctl.op   = vrte_pkg::OP_TOUR;
		q_ctl.last = last;
		q_node     = a_ext[NW-1:0];
		unique case (cmd)
			vrte_pkg::CMD_DEMAND: begin
				keep     = a_in;
				q_ctl.op = vrte_pkg::OP_DEMAND;
			end
			vrte_pkg::CMD_DIST: begin
				keep     = a_in && b_in;
				q_ctl.op = vrte_pkg::OP_DIST;
			end
			vrte_pkg::CMD_TOUR: begin
				keep     = 1'b1;
				q_ctl.op = vrte_pkg::OP_TOUR;
				q_node   = node_map;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign q_col      = b_ext[NW-1:0];
	assign q_value    = value;
	assign in_stall   = q_full;
	assign q_push     = in_valid && !q_full && keep;

endmodule

// File: hw/rtl/vrte_back.sv
// Back part: table memories, tour accumulation pipeline and result queue.
module vrte_back #(
	parameter int MAX_NODES = vrte_pkg::DEF_MAX_NODES,
	parameter int NW        = $clog2(MAX_NODES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [vrte_pkg::CAP_W-1:0] capacity,
	input  logic                       q_valid,
	input  vrte_pkg::vrte_ctl_t        q_ctl,
	input  logic [NW-1:0]              q_node,
	input  logic [NW-1:0]              q_col,
	input  logic [vrte_pkg::DEM_W-1:0] q_value,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [vrte_pkg::SUM_W-1:0] tour_length,
	output logic [vrte_pkg::SUM_W-1:0] capacity_excess,
	output logic                       feasible
);

	localparam int DIST_DEPTH = 1 << (2 * NW);
	localparam int CW         = $clog2(vrte_pkg::OUT_Q_DEPTH + 1);
	localparam int SW         = vrte_pkg::SUM_W;
	localparam int DW         = vrte_pkg::DEM_W;

	logic [DW-1:0] dem_mem  [MAX_NODES];
	logic [DW-1:0] dist_mem [DIST_DEPTH];

	// Issue stage
	logic          is_tour;
	logic          room;
	logic          pop_tour;
	logic          res_take;
	logic [CW-1:0] used_q;
	logic          started_q;
	logic [NW-1:0] first_q;
	logic [NW-1:0] prev_q;
	logic [NW-1:0] prev_row;
	logic [NW-1:0] close_col;

	// Accumulate stage
	logic          v_s2;
	logic          last_s2;
	logic          add_d1_s2;
	logic          zero_s2;
	logic [DW-1:0] dem_s2;
	logic [DW-1:0] d1_s2;
	logic [DW-1:0] d2_s2;
	logic [SW-1:0] length_q;
	logic [SW-1:0] prefix_q;
	logic [SW-1:0] route_q;
	logic [SW-1:0] excess_q;
	logic          depot_q;
	logic [SW-1:0] len_n;
	logic [SW-1:0] prefix_n;
	logic [SW-1:0] route_n;
	logic [SW-1:0] excess_n;
	logic          depot_n;
	logic [SW-1:0] dem_ext;

	// Closing stages
	logic          v_s3;
	logic [SW-1:0] len_s3;
	logic [SW-1:0] exc_s3;
	logic [SW-1:0] route_s3;
	logic [SW-1:0] prefix_s3;
	logic          depot_s3;
	logic [DW-1:0] d2_s3;
	logic          v_s4;
	logic [SW-1:0] len_s4;
	logic [SW-1:0] exc_s4;
	logic [SW-1:0] fr_s4;
	logic [SW-1:0] exc_fin;

	vrte_pkg::vrte_res_t res_in;
	vrte_pkg::vrte_res_t res_out;

	// Hold a closing element until the result queue has a reserved slot
	assign is_tour  = (q_ctl.op == vrte_pkg::OP_TOUR);
	assign room     = (used_q < CW'(vrte_pkg::OUT_Q_DEPTH));
	assign q_pop    = q_valid && (!(is_tour && q_ctl.last) || room);
	assign pop_tour = q_pop && is_tour;
	assign res_take = out_valid && !out_stall;

	assign prev_row  = started_q ? prev_q : q_node;
	assign close_col = started_q ? first_q : q_node;

	// Count result slots in flight or queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			case ({pop_tour && q_ctl.last, res_take})
				2'b10:   used_q <= used_q + 1'b1;
				2'b01:   used_q <= used_q - 1'b1;
				default: used_q <= used_q;
			endcase
		end
	end

	// Track first and previous node of the open tour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			first_q   <= '0;
			prev_q    <= '0;
		end else if (pop_tour) begin
			prev_q <= q_node;
			if (q_ctl.last) begin
				started_q <= 1'b0;
			end else begin
				started_q <= 1'b1;
				if (!started_q) begin
					first_q <= q_node;
				end
			end
		end
	end

	// Write loads, read demand and both edge distances for tour elements
	always_ff @(posedge clk) begin
		if (q_pop && q_ctl.op == vrte_pkg::OP_DEMAND) begin
			dem_mem[q_node] <= q_value;
		end
		if (q_pop && q_ctl.op == vrte_pkg::OP_DIST) begin
			dist_mem[{q_node, q_col}] <= q_value;
		end
		if (pop_tour) begin
			dem_s2    <= dem_mem[q_node];
			d1_s2     <= dist_mem[{prev_row, q_node}];
			d2_s2     <= dist_mem[{q_node, close_col}];
			last_s2   <= q_ctl.last;
			add_d1_s2 <= started_q;
			zero_s2   <= (q_node == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= pop_tour;
		end
	end

	// Update route sums; a depot visit closes the running route
	assign dem_ext = SW'(dem_s2);

	always_comb begin
		len_n    = add_d1_s2 ? vrte_pkg::sat_add(length_q, SW'(d1_s2)) : length_q;
		prefix_n = prefix_q;
		route_n  = route_q;
		excess_n = excess_q;
		depot_n  = depot_q;
		if (zero_s2) begin
			if (depot_q) begin
				excess_n = vrte_pkg::sat_add(excess_q, vrte_pkg::over_cap(route_q, capacity));
			end
			depot_n = 1'b1;
			route_n = dem_ext;
		end else if (depot_q) begin
			route_n = vrte_pkg::sat_add(route_q, dem_ext);
		end else begin
			prefix_n = vrte_pkg::sat_add(prefix_q, dem_ext);
		end
	end

	// Commit tour state; clear it and hand off on the closing element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			prefix_q <= '0;
			route_q  <= '0;
			excess_q <= '0;
			depot_q  <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			v_s3 <= v_s2 && last_s2;
			if (v_s2) begin
				if (last_s2) begin
					length_q <= '0;
					prefix_q <= '0;
					route_q  <= '0;
					excess_q <= '0;
					depot_q  <= 1'b0;
				end else begin
					length_q <= len_n;
					prefix_q <= prefix_n;
					route_q  <= route_n;
					excess_q <= excess_n;
					depot_q  <= depot_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && last_s2) begin
			len_s3    <= len_n;
			exc_s3    <= excess_n;
			route_s3  <= route_n;
			prefix_s3 <= prefix_n;
			depot_s3  <= depot_n;
			d2_s3     <= d2_s2;
		end
	end

	// Add the closing edge and fold the prefix into the last route
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			len_s4 <= vrte_pkg::sat_add(len_s3, SW'(d2_s3));
			fr_s4  <= depot_s3 ? vrte_pkg::sat_add(route_s3, prefix_s3) : prefix_s3;
			exc_s4 <= exc_s3;
		end
	end

	// Charge the last route and queue the result
	assign exc_fin     = vrte_pkg::sat_add(exc_s4, vrte_pkg::over_cap(fr_s4, capacity));
	assign res_in.len  = len_s4;
	assign res_in.exc  = exc_fin;
	assign res_in.feas = (exc_fin == '0);

	vrte_queue #(
		.WIDTH ($bits(vrte_pkg::vrte_res_t)),
		.DEPTH (vrte_pkg::OUT_Q_DEPTH)
	) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s4),
		.push_data (res_in),
		.full      (),
		.pop       (res_take),
		.pop_data  (res_out),
		.not_empty (out_valid)
	);

	assign tour_length     = res_out.len;
	assign capacity_excess = res_out.exc;
	assign feasible        = res_out.feas;

endmodule

// File: hw/rtl/vehicle_route_tour_evaluator_core.sv
// Giant tour evaluator: a closing element popped from the command queue passes the accumulate
// stage, the closing stages and the result queue before out_valid rises. Throughput is one
// item per cycle, set by the route and length update in the accumulate stage, while no closing
// element waits for a result slot; the result queue holds up to 8 results under output stall.
// Reset clears tour state and queues and sets capacity 0xFFFFFF and node count 128;
// demand and distance memories are not cleared and must be loaded before use.
module vehicle_route_tour_evaluator_core #(
	parameter int MAX_NODES = vrte_pkg::DEF_MAX_NODES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vrte_pkg::ADDR_W-1:0] paddr,
	input  logic [vrte_pkg::DATA_W-1:0] pwdata,
	output logic [vrte_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [vrte_pkg::CMD_W-1:0]  cmd,
	input  logic [vrte_pkg::IDA_W-1:0]  node_a,
	input  logic [vrte_pkg::IDB_W-1:0]  node_b,
	input  logic [vrte_pkg::DEM_W-1:0]  value,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [vrte_pkg::SUM_W-1:0]  tour_length,
	output logic [vrte_pkg::SUM_W-1:0]  capacity_excess,
	output logic                        feasible
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int CQW = $bits(vrte_pkg::vrte_ctl_t) + 2 * NW + vrte_pkg::DEM_W;

	vrte_pkg::vrte_ctl_t        f_ctl;
	vrte_pkg::vrte_ctl_t        b_ctl;
	logic [NW-1:0]              f_node;
	logic [NW-1:0]              f_col;
	logic [vrte_pkg::DEM_W-1:0] f_value;
	logic [NW-1:0]              b_node;
	logic [NW-1:0]              b_col;
	logic [vrte_pkg::DEM_W-1:0] b_value;
	logic                       f_push;
	logic                       cq_full;
	logic                       cq_valid;
	logic                       b_pop;
	logic [CQW-1:0]             cq_out;
	logic [vrte_pkg::CAP_W-1:0] capacity;

	assign pready = 1'b1;

	vrte_front #(
		.MAX_NODES (MAX_NODES),
		.NW        (NW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.node_a   (node_a),
		.node_b   (node_b),
		.value    (value),
		.last     (last),
		.q_full   (cq_full),
		.q_push   (f_push),
		.q_ctl    (f_ctl),
		.q_node   (f_node),
		.q_col    (f_col),
		.q_value  (f_value),
		.capacity (capacity)
	);

	// Decouple decode from execution
	vrte_queue #(
		.WIDTH (CQW),
		.DEPTH (vrte_pkg::CMD_Q_DEPTH)
	) u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_ctl, f_node, f_col, f_value}),
		.full      (cq_full),
		.pop       (b_pop),
		.pop_data  (cq_out),
		.not_empty (cq_valid)
	);

	assign {b_ctl, b_node, b_col, b_value} = cq_out;

	vrte_back #(
		.MAX_NODES (MAX_NODES),
		.NW        (NW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.capacity        (capacity),
		.q_valid         (cq_valid),
		.q_ctl           (b_ctl),
		.q_node          (b_node),
		.q_col           (b_col),
		.q_value         (b_value),
		.q_pop           (b_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.tour_length     (tour_length),
		.capacity_excess (capacity_excess),
		.feasible        (feasible)
	);

endmodule

// File: hw/rtl/vrte_checker.sv
// Port-level checks for the giant tour evaluator, bound to the top level.
module vrte_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [vrte_pkg::ADDR_W-1:0] paddr,
	input logic [vrte_pkg::DATA_W-1:0] pwdata,
	input logic [vrte_pkg::DATA_W-1:0] prdata,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [vrte_pkg::SUM_W-1:0]  tour_length,
	input logic [vrte_pkg::SUM_W-1:0]  capacity_excess,
	input logic                        feasible
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tour_length)
			&& $stable(capacity_excess) && $stable(feasible))
		else $error("result beat changed while stalled");

	// Feasible flag agrees with the excess
	a_feasible: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> feasible == (capacity_excess == '0))
		else $error("feasible flag disagrees with capacity excess");

	// Capacity reads back what was just written
	a_cap_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == vrte_pkg::REG_CAPACITY)
		##1 (psel && !pwrite && paddr[2] == vrte_pkg::REG_CAPACITY)
		|-> prdata[vrte_pkg::CAP_W-1:0] == $past(pwdata[vrte_pkg::CAP_W-1:0]))
		else $error("capacity readback mismatch");

	// Node count reads back what was just written
	a_nodes_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == vrte_pkg::REG_NODES)
		##1 (psel && !pwrite && paddr[2] == vrte_pkg::REG_NODES)
		|-> prdata[vrte_pkg::NCNT_W-1:0] == $past(pwdata[vrte_pkg::NCNT_W-1:0]))
		else $error("node count readback mismatch");

endmodule

bind vehicle_route_tour_evaluator_core vrte_checker u_vrte_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.psel            (psel),
	.penable         (penable),
	.pwrite          (pwrite),
	.paddr           (paddr),
	.pwdata          (pwdata),
	.prdata          (prdata),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.tour_length     (tour_length),
	.capacity_excess (capacity_excess),
	.feasible        (feasible)
);
